@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file pcp_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: next-cycle property");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: same-cycle property");

`endif

@@ rtl/pcp_pkg.sv @@
// Package: widths, limits and sequencer states of the partition counter.
package pcp_pkg;

    localparam int MAX_TOTAL = 256;
    localparam int TOT_W     = 9;
    localparam int WAYS_W    = 49;
    localparam int DEPTH     = MAX_TOTAL;
    localparam int ADDR_W    = $clog2(MAX_TOTAL);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_UPDATE,
        S_DRAIN,
        S_READ,
        S_FINISH
    } pcp_state_t;

endpackage

@@ rtl/partition_count_k_parts_unit.sv @@
// Top level: counts partitions of a total into exactly k positive parts.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------------
//  request   | start (in), busy (out)    | total[8:0], parts[8:0]
//  result    | done (out), one-cycle beat| ways[48:0]
//
// A request beat is taken on a clock edge with start high and busy low.
// Trivial requests (total above the limit, parts at least total, parts zero)
// answer with a done beat in the next cycle and busy never rises.
// Otherwise, with r = total - parts and smax = min(parts, r), the item clears t[0..r],
// then for s = 1..smax adds t[m-s] into t[m] for m = s..r, one table update per cycle
// through the single 49-bit adder and the table memory, then reads t[r] and beats done.
// rst_n is asynchronous and clears the sequencer; the table is not cleared.
// The receiver cannot stall: done is a single-cycle strobe.
module partition_count_k_parts_unit
    import pcp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [TOT_W-1:0]    total,
    input  logic [TOT_W-1:0]    parts,
    output logic                busy,
    output logic                done,
    output logic [WAYS_W-1:0]   ways
);

    // Sequencer state
    pcp_state_t state_reg, state_next;

    // Item bounds and loop counters
    logic [ADDR_W-1:0] r_reg,    r_next;     // remaining units: total - parts
    logic [ADDR_W-1:0] smax_reg, smax_next;  // largest part size applied
    logic [ADDR_W-1:0] s_reg,    s_next;     // current part size
    logic [ADDR_W-1:0] m_reg,    m_next;     // current table index

    // Result registers
    logic              done_reg, done_next;
    logic [WAYS_W-1:0] ways_reg, ways_next;

    // Update pipeline: issue reads, then add and write back
    logic              p1_valid_reg, p1_valid_next;
    logic [ADDR_W-1:0] p1_addr_reg,  p1_addr_next;
    logic              fwd_a_reg,    fwd_a_next;
    logic              fwd_b_reg,    fwd_b_next;
    logic [WAYS_W-1:0] fwd_data_reg, fwd_data_next;

    // Table memory and its registered read ports
    logic [WAYS_W-1:0] table_mem [DEPTH];
    logic [WAYS_W-1:0] rd_a_reg;
    logic [WAYS_W-1:0] rd_b_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WAYS_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] b_addr;
    logic              issue;
    logic [WAYS_W-1:0] op_a;
    logic [WAYS_W-1:0] op_b;
    logic [WAYS_W-1:0] sum;

    // Request classification
    logic [TOT_W-1:0]  diff;
    logic              over_limit;
    logic              parts_ge_total;
    logic              parts_zero;
    logic              nontrivial;

    assign diff           = total - parts;
    assign over_limit     = ({1'b0, total} > (TOT_W+1)'(MAX_TOTAL));
    assign parts_ge_total = (total <= parts);
    assign parts_zero     = (parts == '0);
    assign nontrivial     = !over_limit && !parts_ge_total && !parts_zero;

    // t[m] gains t[m-s]; a read that collides with the write of the same
    // edge takes the value being written instead of the stale word.
    assign b_addr = m_reg - s_reg;
    assign op_a   = fwd_a_reg ? fwd_data_reg : rd_a_reg;
    assign op_b   = fwd_b_reg ? fwd_data_reg : rd_b_reg;
    assign sum    = op_a + op_b;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && nontrivial)
                    state_next = S_CLEAR;
            end
            S_CLEAR:
            begin
                if (m_reg == r_reg)
                    state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (m_reg == r_reg && s_reg == smax_reg)
                    state_next = S_DRAIN;
            end
            S_DRAIN:  state_next = S_READ;
            S_READ:   state_next = S_FINISH;
            S_FINISH: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Control outputs: memory write port, issue strobe, busy
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = p1_addr_reg;
        mem_wdata = sum;
        issue     = 1'b0;
        busy      = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
            end
            S_CLEAR:
            begin
                // t[0] = 1, t[1..r] = 0
                mem_we    = 1'b1;
                mem_waddr = m_reg;
                mem_wdata = (m_reg == '0) ? WAYS_W'(1) : '0;
            end
            S_UPDATE:
            begin
                issue  = 1'b1;
                mem_we = p1_valid_reg;
            end
            default:
            begin
                mem_we = p1_valid_reg;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        r_next        = r_reg;
        smax_next     = smax_reg;
        s_next        = s_reg;
        m_next        = m_reg;
        done_next     = 1'b0;
        ways_next     = ways_reg;
        p1_valid_next = issue;
        p1_addr_next  = m_reg;
        fwd_a_next    = p1_valid_reg && (m_reg == p1_addr_reg);
        fwd_b_next    = p1_valid_reg && (b_addr == p1_addr_reg);
        fwd_data_next = sum;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    r_next    = ADDR_W'(diff);
                    smax_next = (parts < diff) ? ADDR_W'(parts) : ADDR_W'(diff);
                    s_next    = ADDR_W'(1);
                    m_next    = '0;
                    if (over_limit)
                    begin
                        done_next = 1'b1;
                        ways_next = '0;
                    end
                    else if (parts_ge_total)
                    begin
                        done_next = 1'b1;
                        ways_next = WAYS_W'(1);
                    end
                    else if (parts_zero)
                    begin
                        done_next = 1'b1;
                        ways_next = '0;
                    end
                end
            end
            S_CLEAR:
            begin
                m_next = (m_reg == r_reg) ? ADDR_W'(1) : m_reg + ADDR_W'(1);
            end
            S_UPDATE:
            begin
                if (m_reg == r_reg)
                begin
                    if (s_reg != smax_reg)
                    begin
                        s_next = s_reg + ADDR_W'(1);
                        m_next = s_reg + ADDR_W'(1);
                    end
                end
                else
                begin
                    m_next = m_reg + ADDR_W'(1);
                end
            end
            S_FINISH:
            begin
                // rd_a_reg holds t[r], read in S_READ
                done_next = 1'b1;
                ways_next = rd_a_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            done_reg     <= 1'b0;
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= done_next;
            p1_valid_reg <= p1_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        r_reg        <= r_next;
        smax_reg     <= smax_next;
        s_reg        <= s_next;
        m_reg        <= m_next;
        ways_reg     <= ways_next;
        p1_addr_reg  <= p1_addr_next;
        fwd_a_reg    <= fwd_a_next;
        fwd_b_reg    <= fwd_b_next;
        fwd_data_reg <= fwd_data_next;
    end

    // Table memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
            table_mem[mem_waddr] <= mem_wdata;
        rd_a_reg <= table_mem[m_reg];
        rd_b_reg <= table_mem[b_addr];
    end

    assign done = done_reg;
    assign ways = ways_reg;

endmodule

@@ rtl/pcp_checker.sv @@
// Checker: port-level properties of the partition counter, bound to the top.
`include "assert_macros.svh"

module pcp_checker
    import pcp_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic [TOT_W-1:0]  total,
    input logic [TOT_W-1:0]  parts,
    input logic              busy,
    input logic              done,
    input logic [WAYS_W-1:0] ways
);

    logic take;
    logic over_limit;
    logic nontrivial;

    assign take       = start && !busy;
    assign over_limit = ({1'b0, total} > (TOT_W+1)'(MAX_TOTAL));
    assign nontrivial = !over_limit && (parts < total) && (parts != '0);

    `ASSERT_NEXT(a_over_limit_zero, clk, rst_n, take && over_limit, done && ways == '0)
    `ASSERT_NEXT(a_one_way, clk, rst_n, take && !over_limit && parts >= total, done && ways == WAYS_W'(1))
    `ASSERT_NEXT(a_long_item_busy, clk, rst_n, take && nontrivial, busy && !done)
    `ASSERT_SAME(a_done_at_end, clk, rst_n, $fell(busy), done)

endmodule

bind partition_count_k_parts_unit pcp_checker u_pcp_checker (.*);

@@ verif/tb_partition_count_k_parts_unit.sv @@
// Testbench for partition_count_k_parts_unit: directed table plus random requests.
module tb_partition_count_k_parts_unit
    import pcp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Run shape
    localparam int NUM_DIRECTED   = 23;
    localparam int NUM_RANDOM     = 100;
    localparam int CALM_FIRST     = 30;      // random beats [CALM_FIRST, CALM_LAST) never idle
    localparam int CALM_LAST      = 60;
    localparam int IDLE_PERCENT   = 38;
    localparam int DRAIN_CYCLES   = 16;      // trivial requests answer in the next cycle
    // Worst item is total 256, parts near 85; leave lots of slack.
    localparam int WATCHDOG_LIMIT = 100000;

    // One row of the directed table. When fixed_exp is set, ways is the typed-in answer;
    // otherwise the row is scored by the predictor.
    typedef struct packed {
        logic [TOT_W-1:0]  total;
        logic [TOT_W-1:0]  parts;
        logic              fixed_exp;
        logic [WAYS_W-1:0] ways;
    } req_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic [TOT_W-1:0]    total;
    logic [TOT_W-1:0]    parts;
    logic                busy;
    logic                done;
    logic [WAYS_W-1:0]   ways;

    // Expected counts, oldest first, one per accepted request beat.
    logic [WAYS_W-1:0]   expected_ways_q [$];
    // Predictor's working table: bounded-part counts for 0..r.
    logic [WAYS_W-1:0]   bounded_counts [0:MAX_TOTAL-1];

    int unsigned         errors     = 0;
    int unsigned         n_sent     = 0;
    int unsigned         n_checked  = 0;
    int unsigned         n_trivial  = 0;
    int unsigned         idle_count = 0;

    req_row_t directed_rows [NUM_DIRECTED] = '{
        // parts at least total, including total zero
        '{9'd1,   9'd1,   1'b1, 49'd1},
        '{9'd0,   9'd0,   1'b1, 49'd1},
        '{9'd0,   9'd511, 1'b1, 49'd1},
        // parts zero with a positive total
        '{9'd5,   9'd0,   1'b1, 49'd0},
        '{9'd256, 9'd0,   1'b1, 49'd0},
        '{9'd1,   9'd0,   1'b1, 49'd0},
        // total above the limit: rejected, ways zero
        '{9'd257, 9'd1,   1'b1, 49'd0},
        '{9'd511, 9'd511, 1'b1, 49'd0},
        '{9'd300, 9'd0,   1'b1, 49'd0},
        // edges of the accepted range
        '{9'd256, 9'd256, 1'b1, 49'd1},
        '{9'd255, 9'd511, 1'b1, 49'd1},
        '{9'd256, 9'd1,   1'b1, 49'd1},
        '{9'd256, 9'd255, 1'b1, 49'd1},
        '{9'd256, 9'd2,   1'b1, 49'd128},
        '{9'd2,   9'd1,   1'b1, 49'd1},
        '{9'd128, 9'd127, 1'b1, 49'd1},
        // real table passes, scored by the predictor
        '{9'd10,  9'd3,   1'b0, 49'd0},
        '{9'd7,   9'd2,   1'b0, 49'd0},
        '{9'd256, 9'd85,  1'b0, 49'd0},   // near the longest pass
        '{9'd256, 9'd128, 1'b0, 49'd0},
        '{9'd170, 9'd85,  1'b0, 49'd0},
        '{9'd256, 9'd64,  1'b0, 49'd0},
        '{9'd200, 9'd170, 1'b0, 49'd0}
    };

    partition_count_k_parts_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .total (total),
        .parts (parts),
        .busy  (busy),
        .done  (done),
        .ways  (ways)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Count of splits of n into exactly k positive parts. Same as splits of n - k into
    // parts no larger than k: coin-style table over part sizes 1..min(k, r).
    function automatic logic [WAYS_W-1:0] count_partitions(input int unsigned n,
                                                           input int unsigned k);
        int unsigned r;
        int unsigned smax;
        int unsigned m;
        int unsigned s;
        if (n > MAX_TOTAL)
            return '0;
        if (n <= k)
            return WAYS_W'(1);
        if (k == 0)
            return '0;
        r = n - k;
        bounded_counts[0] = WAYS_W'(1);
        for (m = 1; m <= r; m++)
            bounded_counts[m] = '0;
        smax = (k < r) ? k : r;
        for (s = 1; s <= smax; s++)
            for (m = s; m <= r; m++)
                bounded_counts[m] = bounded_counts[m] + bounded_counts[m - s];   // wraps at 49 bits
        return bounded_counts[r];
    endfunction

    // Present one request beat, hold it until start meets busy low at an edge, queue the
    // expected count, then maybe leave start low for a while.
    task automatic issue_request(input logic [TOT_W-1:0] t, input logic [TOT_W-1:0] p,
                                 input logic [WAYS_W-1:0] want, input bit may_idle);
        int unsigned gap;
        start <= 1'b1;
        total <= t;
        parts <= p;
        do
            @(posedge clk);
        while (busy);
        expected_ways_q.push_back(want);
        n_sent++;
        if (t > MAX_TOTAL || p >= t || p == 0)
            n_trivial++;
        if (may_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
            // mostly short gaps, some long enough to land deep inside a table pass
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 200) : $urandom_range(1, 6);
            idle_count++;
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Random request mix: mostly real passes at small totals, a few at large totals,
    // plus trivial, zero-part and rejected requests so every input bit toggles.
    task automatic random_request(output logic [TOT_W-1:0] t, output logic [TOT_W-1:0] p);
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            t = TOT_W'($urandom_range(MAX_TOTAL + 1, 511));
            p = TOT_W'($urandom_range(0, 511));
        end else if (pick < 20) begin
            n = $urandom_range(0, MAX_TOTAL);
            t = TOT_W'(n);
            p = TOT_W'($urandom_range(n, 511));
        end else if (pick < 25) begin
            t = TOT_W'($urandom_range(1, MAX_TOTAL));
            p = '0;
        end else if (pick < 90) begin
            n = $urandom_range(2, 48);
            t = TOT_W'(n);
            p = TOT_W'($urandom_range(1, n - 1));
        end else begin
            n = $urandom_range(200, MAX_TOTAL);
            t = TOT_W'(n);
            p = TOT_W'($urandom_range(1, n - 1));
        end
    endtask

    // Stimulus
    initial begin
        logic [TOT_W-1:0]  t;
        logic [TOT_W-1:0]  p;
        logic [WAYS_W-1:0] want;
        int                i;
        rst_n = 1'b0;
        start = 1'b0;
        total = '0;
        parts = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (i = 0; i < NUM_DIRECTED; i++) begin
            t = directed_rows[i].total;
            p = directed_rows[i].parts;
            want = directed_rows[i].fixed_exp ? directed_rows[i].ways : count_partitions(t, p);
            issue_request(t, p, want, 1'b1);
        end

        // random requests, with one calm stretch of back-to-back beats
        for (i = 0; i < NUM_RANDOM; i++) begin
            random_request(t, p);
            issue_request(t, p, count_partitions(t, p), !(i >= CALM_FIRST && i < CALM_LAST));
        end
        // after an idle gap start already reads low; otherwise drop it now
        if (start)
            start <= 1'b0;

        // drain, then a few cycles to catch any stray result beat
        while (expected_ways_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d request beats (%0d directed, %0d random), %0d trivial or rejected.",
                 n_sent, NUM_DIRECTED, NUM_RANDOM, n_trivial);
        $display("Checked %0d result beats; sender idled after %0d beats.", n_checked, idle_count);
        if (errors == 0 && expected_ways_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Scoreboard: each done beat is scored against the oldest expected count.
    always @(posedge clk) begin
        logic [WAYS_W-1:0] want;
        if (rst_n && done) begin
            if (expected_ways_q.size() == 0) begin
                $error("unexpected result beat: ways actual %0d", ways);
                errors++;
            end else begin
                want = expected_ways_q.pop_front();
                n_checked++;
                if (ways !== want) begin
                    $error("ways mismatch: expected %0d, actual %0d", want, ways);
                    errors++;
                end
            end
        end
    end

    // Watchdog: cycles with neither a request beat nor a result beat.
    always @(posedge clk) begin
        int unsigned quiet;
        if (!rst_n || (start && !busy) || done)
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no beat in %0d cycles, %0d results outstanding.",
                     quiet, expected_ways_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/pcp_pkg.sv
rtl/partition_count_k_parts_unit.sv
rtl/pcp_checker.sv
verif/tb_partition_count_k_parts_unit.sv
